[hw/rtl/ias_pkg.sv]
// Shared constants and types for the integer array sorter.
`timescale 1ns / 1ps

package ias_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RUN_W     = CNT_W + 1;
  localparam int SUM_W     = CNT_W + 2;

  typedef struct packed {
    logic a_ok;
    logic b_ok;
  } cmp_req_t;

  typedef struct packed {
    logic              take_a;
    logic [DATA_W-1:0] data;
  } cmp_res_t;

endpackage

[hw/rtl/integer_array_sorter_top.sv]
// Top level of the integer array sorter: load, merge sort sequencer and output.
//
//  channel | direction | tdata                 | side band
//  --------+-----------+-----------------------+---------------------------------
//  in_     | slave     | [31:0] value          | tlast: last value of the set
//  out_    | master    | [31:0] sorted_value   | tlast: end_of_set, tuser: overflow
//
// Loading accepts one value per cycle. After the last value, a bottom-up merge sort runs
// through one comparator and a two-bank memory with two read ports: ceil(log2 N) passes,
// each opened by a priming state (S_PRIME), then a priming state for the read-out
// (S_OPRIME) before the values are emitted. The memory's single write port sets the pace.
// Reset (rst_n, synchronous, active low) empties the set; a stalled output only delays
// the read-out, and the next set is taken as soon as the final result is registered.
`timescale 1ns / 1ps

module integer_array_sorter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,
  output logic        out_tuser   // [0] overflow
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_PRIME  = 3'd1;
  localparam logic [2:0] S_MERGE  = 3'd2;
  localparam logic [2:0] S_OPRIME = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  localparam int DW = ias_pkg::DATA_W;
  localparam int CW = ias_pkg::CNT_W;
  localparam int RW = ias_pkg::RUN_W;
  localparam int SW = ias_pkg::SUM_W;
  localparam int IW = ias_pkg::IDX_W;
  localparam int AW = ias_pkg::ADDR_W;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic          bank_r, bank_nxt;
  logic [RW-1:0] run_r, run_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] iend_r, iend_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] jend_r, jend_nxt;
  logic [CW-1:0] k_r, k_nxt;

  logic          out_tvalid_r, out_tvalid_nxt;
  logic [DW-1:0] out_tdata_r, out_tdata_nxt;
  logic          out_tlast_r, out_tlast_nxt;
  logic          out_tuser_r, out_tuser_nxt;

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en;

  logic          in_acc;
  logic          full;
  logic [CW-1:0] load_n;
  logic          load_out;
  logic          seg_done;
  logic          pass_done;
  logic [RW-1:0] run_dbl;

  logic [CW-1:0] seg_lo;
  logic [RW-1:0] seg_run;
  logic [CW-1:0] seg_n;
  logic [SW-1:0] seg_mid_full, seg_hi_full;
  logic [CW-1:0] seg_mid, seg_hi;

  ias_pkg::cmp_req_t cmp_req;
  ias_pkg::cmp_res_t cmp_res;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (cnt_r >= CW'(ias_pkg::MAX_ITEMS));
  assign load_n    = full ? cnt_r : cnt_r + CW'(1);
  assign load_out  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  assign cmp_req.a_ok = (i_r < iend_r);
  assign cmp_req.b_ok = (j_r < jend_r);

  ias_cmp_unit u_cmp (
    .a   (rd_a_q),
    .b   (rd_b_q),
    .req (cmp_req),
    .res (cmp_res)
  );

  assign seg_done  = ((k_r + CW'(1)) == jend_r);
  assign pass_done = (jend_r == cnt_r);
  assign run_dbl   = run_r << 1;

  // Bounds of the next pair of runs to merge, clamped to the set size.
  always_comb begin
    if (state_r == S_MERGE) begin
      seg_lo  = pass_done ? '0 : jend_r;
      seg_run = pass_done ? run_dbl : run_r;
    end else begin
      seg_lo  = '0;
      seg_run = RW'(1);
    end
    seg_n        = (state_r == S_LOAD) ? load_n : cnt_r;
    seg_mid_full = SW'(seg_lo) + SW'(seg_run);
    seg_hi_full  = SW'(seg_lo) + (SW'(seg_run) << 1);
    seg_mid      = (seg_mid_full >= SW'(seg_n)) ? seg_n : seg_mid_full[CW-1:0];
    seg_hi       = (seg_hi_full >= SW'(seg_n)) ? seg_n : seg_hi_full[CW-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    drop_nxt       = drop_r;
    bank_nxt       = bank_r;
    run_nxt        = run_r;
    i_nxt          = i_r;
    iend_nxt       = iend_r;
    j_nxt          = j_r;
    jend_nxt       = jend_r;
    k_nxt          = k_r;
    wr_en          = 1'b0;
    wr_addr        = {1'b0, cnt_r[IW-1:0]};
    wr_data        = in_tdata;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    out_tuser_nxt  = out_tuser_r;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            wr_en   = 1'b1;
            cnt_nxt = load_n;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            bank_nxt = 1'b0;
            i_nxt    = '0;
            if (load_n < CW'(2)) begin
              state_nxt = S_OPRIME;
            end else begin
              state_nxt = S_PRIME;
              run_nxt   = RW'(1);
              iend_nxt  = seg_mid;
              j_nxt     = seg_mid;
              jend_nxt  = seg_hi;
              k_nxt     = '0;
            end
          end
        end
      end
      S_PRIME: begin
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = {~bank_r, k_r[IW-1:0]};
        wr_data = cmp_res.data;
        if (seg_done) begin
          i_nxt    = seg_lo;
          iend_nxt = seg_mid;
          j_nxt    = seg_mid;
          jend_nxt = seg_hi;
          k_nxt    = seg_lo;
          if (pass_done) begin
            // The pass wrote the other bank; the next reads must wait for the last write.
            bank_nxt = ~bank_r;
            run_nxt  = run_dbl;
            if (run_dbl >= RW'(cnt_r)) begin
              state_nxt = S_OPRIME;
              i_nxt     = '0;
            end else begin
              state_nxt = S_PRIME;
            end
          end
        end else begin
          i_nxt = i_r + CW'(cmp_res.take_a);
          j_nxt = j_r + CW'(!cmp_res.take_a);
          k_nxt = k_r + CW'(1);
        end
      end
      S_OPRIME: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = rd_a_q;
          out_tlast_nxt  = (i_r == cnt_r - CW'(1));
          out_tuser_nxt  = drop_r;
          i_nxt          = i_r + CW'(1);
          if (i_r == cnt_r - CW'(1)) begin
            state_nxt = S_LOAD;
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            bank_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Read addresses follow the next pointers, so the registered data matches them.
  assign rd_a_addr = {bank_nxt, i_nxt[IW-1:0]};
  assign rd_b_addr = {bank_nxt, j_nxt[IW-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      cnt_r        <= '0;
      drop_r       <= 1'b0;
      bank_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      drop_r       <= drop_nxt;
      bank_r       <= bank_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r       <= run_nxt;
    i_r         <= i_nxt;
    iend_r      <= iend_nxt;
    j_r         <= j_nxt;
    jend_r      <= jend_nxt;
    k_r         <= k_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ias_pkg::MAX_ITEMS))
    else $error("element count beyond capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> cnt_r == CW'(ias_pkg::MAX_ITEMS))
    else $error("drop flagged while the store has room");

  a_merge_wr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE |-> k_r < cnt_r && k_r < jend_r)
    else $error("merge write outside the set");

  a_out_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> i_r < cnt_r)
    else $error("read-out pointer outside the set");

endmodule

[hw/rtl/ias_cmp_unit.sv]
// Shared signed compare and select unit used by every merge step.
`timescale 1ns / 1ps

module ias_cmp_unit (
  input  logic [ias_pkg::DATA_W-1:0] a,
  input  logic [ias_pkg::DATA_W-1:0] b,
  input  ias_pkg::cmp_req_t          req,
  output ias_pkg::cmp_res_t          res
);

  logic a_le_b;

  assign a_le_b = $signed(a) <= $signed(b);

  // The left run wins ties, which keeps the merge stable.
  always_comb begin
    res.take_a = req.a_ok && (!req.b_ok || a_le_b);
    res.data   = res.take_a ? a : b;
  end

endmodule
